>>> src/ultrasonic_echo_ranger_defines.svh
// assertion macros for the ultrasonic echo ranger
// included by the modules that check their own logic
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

`ifndef SYNTHESIS

`define UER_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define UER_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UER_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define UER_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/uer_pkg.sv
// shared types and constants of the ultrasonic echo ranger
// no dependencies
package uer_pkg;

    localparam int unsigned TRIG_W = 8;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned DATA_W = 16;

    localparam logic [IDX_W-1:0] REG_TRIGGER_US   = 2'd0;
    localparam logic [IDX_W-1:0] REG_RISE_TIMEOUT = 2'd1;
    localparam logic [IDX_W-1:0] REG_ECHO_TIMEOUT = 2'd2;
    localparam logic [IDX_W-1:0] REG_US_PER_CM    = 2'd3;

    localparam logic [TRIG_W-1:0] RST_TRIGGER_US   = 8'd10;
    localparam logic [CNT_W-1:0]  RST_RISE_TIMEOUT = 16'd1000;
    localparam logic [CNT_W-1:0]  RST_ECHO_TIMEOUT = 16'd25000;
    localparam logic [CNT_W-1:0]  RST_US_PER_CM    = 16'd58;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ECHO = 2'd1;
    localparam logic [1:0] ST_NO_RESP = 2'd2;

    typedef struct packed {
        logic             trig;
        logic             busy;
        logic             done;
        logic [1:0]       status;
        logic [CNT_W-1:0] distance;
    } t_result;

endpackage

>>> src/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger. Every accepted request is one microsecond tick and
// yields one registered result, so one request per clock is taken unless the
// input is stalled. A start while idle runs trigger low, trigger high, wait for
// echo rise and echo timing; distance is the high tick count divided by
// us_per_cm, counted with a prescaler. Results sit in an output register backed
// by one skid entry, so the input stalls only when both are full.
// depends on uer_pkg and ultrasonic_echo_ranger_defines.svh
`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_start_req,
    input  logic              i_echo_level,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_trigger_out,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic [1:0]        o_status,
    output logic [CNT_W-1:0]  o_distance_cm
);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
    localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
    localparam logic [2:0] PH_WAIT_RISE = 3'd3;
    localparam logic [2:0] PH_MEASURE   = 3'd4;

    logic [TRIG_W-1:0] r_trigger_us;
    logic [CNT_W-1:0]  r_rise_timeout;
    logic [CNT_W-1:0]  r_echo_timeout;
    logic [CNT_W-1:0]  r_us_per_cm;

    logic [2:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_tick, n_tick;
    logic [CNT_W-1:0] r_presc, n_presc;
    logic [CNT_W-1:0] r_dist, n_dist;

    t_result r_out, r_skid, n_res;
    logic    r_ovalid, r_svalid;

    logic in_fire, out_fire;
    logic [CNT_W-1:0] hi_tick, hi_presc, hi_dist, tick_inc;
    logic             hi_timeout;

    assign o_in_stall  = r_svalid;
    assign in_fire     = i_in_valid && !r_svalid;
    assign out_fire    = r_ovalid && !i_out_stall;
    assign o_out_valid = r_ovalid;

    assign o_trigger_out = r_out.trig;
    assign o_busy_res    = r_out.busy;
    assign o_done_res    = r_out.done;
    assign o_status      = r_out.status;
    assign o_distance_cm = r_out.distance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_us   <= RST_TRIGGER_US;
            r_rise_timeout <= RST_RISE_TIMEOUT;
            r_echo_timeout <= RST_ECHO_TIMEOUT;
            r_us_per_cm    <= RST_US_PER_CM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TRIGGER_US:   r_trigger_us   <= i_cfg_data[TRIG_W-1:0];
                REG_RISE_TIMEOUT: r_rise_timeout <= i_cfg_data[CNT_W-1:0];
                REG_ECHO_TIMEOUT: r_echo_timeout <= i_cfg_data[CNT_W-1:0];
                REG_US_PER_CM:    r_us_per_cm    <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // one high echo tick, starting from fresh counters on the rise tick
    always_comb begin
        logic [CNT_W-1:0] base_tick, base_presc, base_dist;
        if (r_phase == PH_MEASURE) begin
            base_tick  = r_tick;
            base_presc = r_presc;
            base_dist  = r_dist;
        end else begin
            base_tick  = '0;
            base_presc = '0;
            base_dist  = '0;
        end
        hi_tick  = base_tick + CNT_W'(1);
        hi_presc = base_presc + CNT_W'(1);
        hi_dist  = base_dist;
        if (hi_presc >= r_us_per_cm) begin
            hi_presc = '0;
            hi_dist  = base_dist + CNT_W'(1);
        end
        hi_timeout = (hi_tick >= r_echo_timeout);
    end

    // per tick sequencer
    always_comb begin
        logic [2:0] cur_phase;
        logic [CNT_W-1:0] cur_tick;
        cur_phase = r_phase;
        cur_tick  = r_tick;
        if (r_phase == PH_IDLE && i_start_req) begin
            cur_phase = PH_TRIG_LOW;
            cur_tick  = '0;
        end
        tick_inc = cur_tick + CNT_W'(1);

        n_phase = cur_phase;
        n_tick  = cur_tick;
        n_presc = r_presc;
        n_dist  = r_dist;
        n_res   = '{trig: 1'b0, busy: 1'b0, done: 1'b0, status: ST_OK, distance: '0};

        unique case (cur_phase)
            PH_IDLE: begin
            end
            PH_TRIG_LOW: begin
                n_res.busy = 1'b1;
                n_tick     = tick_inc;
                if (tick_inc >= CNT_W'(r_trigger_us)) begin
                    n_phase = PH_TRIG_HIGH;
                    n_tick  = '0;
                end
            end
            PH_TRIG_HIGH: begin
                n_res.trig = 1'b1;
                n_res.busy = 1'b1;
                n_tick     = tick_inc;
                if (tick_inc >= CNT_W'(r_trigger_us)) begin
                    n_phase = PH_WAIT_RISE;
                    n_tick  = '0;
                end
            end
            PH_WAIT_RISE: begin
                n_res.busy = 1'b1;
                if (i_echo_level) begin
                    n_phase = PH_MEASURE;
                    n_tick  = hi_tick;
                    n_presc = hi_presc;
                    n_dist  = hi_dist;
                    if (hi_timeout) begin
                        n_res.done   = 1'b1;
                        n_res.status = ST_NO_ECHO;
                    end
                end else begin
                    n_tick = tick_inc;
                    if (tick_inc >= r_rise_timeout) begin
                        n_res.done   = 1'b1;
                        n_res.status = ST_NO_RESP;
                    end
                end
            end
            PH_MEASURE: begin
                n_res.busy = 1'b1;
                if (!i_echo_level) begin
                    n_res.done     = 1'b1;
                    n_res.distance = r_dist;
                end else begin
                    n_tick  = hi_tick;
                    n_presc = hi_presc;
                    n_dist  = hi_dist;
                    if (hi_timeout) begin
                        n_res.done   = 1'b1;
                        n_res.status = ST_NO_ECHO;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (n_res.done) begin
            n_res.busy = 1'b0;
            n_phase    = PH_IDLE;
            n_tick     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_presc <= '0;
            r_dist  <= '0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_presc <= n_presc;
            r_dist  <= n_dist;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_svalid <= 1'b0;
        end else if (r_svalid) begin
            if (out_fire) begin
                r_svalid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_ovalid || out_fire) begin
                r_ovalid <= 1'b1;
            end else begin
                r_svalid <= 1'b1;
            end
        end else if (out_fire) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_svalid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (!r_ovalid || out_fire) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    `UER_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_svalid, r_ovalid, "skid full with output empty")
    `UER_ASSERT_NXT(a_done_to_idle, i_clk, i_rst_n, in_fire && n_res.done, (r_phase == PH_IDLE) && (r_tick == '0), "finished measurement did not return to idle")
    `UER_ASSERT_IMP(a_status_on_done, i_clk, i_rst_n, r_ovalid && (r_out.status != ST_OK), r_out.done && !r_out.busy, "error status without done")
    `UER_ASSERT_IMP(a_dist_bound, i_clk, i_rst_n, r_phase == PH_MEASURE, r_dist <= r_tick, "distance ahead of high tick count")

endmodule

>>> tb/echo_ranger_monitor.sv
`timescale 1ns / 1ps
// request and result monitor for the ultrasonic echo ranger: predicts every tick
// from its own copy of the registers and state, and compares each result in order
// depends on uer_pkg
module echo_ranger_monitor
    import uer_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_start_req,
    input  logic              i_echo_level,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_trigger_out,
    input  logic              i_busy_res,
    input  logic              i_done_res,
    input  logic [1:0]        i_status,
    input  logic [CNT_W-1:0]  i_distance_cm,
    output int                o_fail_count,
    output int                o_pending
);

    typedef enum logic [2:0] {
        RNG_IDLE,
        RNG_TRIG_LOW,
        RNG_TRIG_HIGH,
        RNG_WAIT_RISE,
        RNG_MEASURE
    } t_ranger_phase;

    logic [TRIG_W-1:0] trig_len;
    logic [CNT_W-1:0]  rise_limit;
    logic [CNT_W-1:0]  echo_limit;
    logic [CNT_W-1:0]  cm_div;

    t_ranger_phase     phase;
    logic [CNT_W-1:0]  ticks;
    logic [CNT_W-1:0]  prescale;
    logic [CNT_W-1:0]  dist_acc;

    t_result           expected_reports[$];
    int                fails = 0;

    task automatic count_high_tick(output logic expired);
        ticks    = ticks + 1'b1;
        prescale = prescale + 1'b1;
        if (prescale >= cm_div) begin
            prescale = '0;
            dist_acc = dist_acc + 1'b1;
        end
        expired = (ticks >= echo_limit);
    endtask

    task automatic predict_tick(input logic start, input logic echo, output t_result res);
        logic expired;
        res        = '0;
        res.status = ST_OK;
        expired    = 1'b0;
        if (phase == RNG_IDLE && start) begin
            phase = RNG_TRIG_LOW;
            ticks = '0;
        end
        case (phase)
            RNG_TRIG_LOW, RNG_TRIG_HIGH: begin
                res.trig = (phase == RNG_TRIG_HIGH);
                res.busy = 1'b1;
                ticks    = ticks + 1'b1;
                if (ticks >= trig_len) begin
                    phase = (phase == RNG_TRIG_LOW) ? RNG_TRIG_HIGH : RNG_WAIT_RISE;
                    ticks = '0;
                end
            end
            RNG_WAIT_RISE: begin
                res.busy = 1'b1;
                if (echo) begin
                    phase    = RNG_MEASURE;
                    ticks    = '0;
                    prescale = '0;
                    dist_acc = '0;
                    count_high_tick(expired);
                    if (expired) begin
                        res.done   = 1'b1;
                        res.status = ST_NO_ECHO;
                    end
                end else begin
                    ticks = ticks + 1'b1;
                    if (ticks >= rise_limit) begin
                        res.done   = 1'b1;
                        res.status = ST_NO_RESP;
                    end
                end
            end
            RNG_MEASURE: begin
                res.busy = 1'b1;
                if (!echo) begin
                    res.done     = 1'b1;
                    res.status   = ST_OK;
                    res.distance = dist_acc;
                end else begin
                    count_high_tick(expired);
                    if (expired) begin
                        res.done   = 1'b1;
                        res.status = ST_NO_ECHO;
                    end
                end
            end
            default: phase = RNG_IDLE;
        endcase
        if (res.done) begin
            res.busy = 1'b0;
            phase    = RNG_IDLE;
            ticks    = '0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            trig_len   = RST_TRIGGER_US;
            rise_limit = RST_RISE_TIMEOUT;
            echo_limit = RST_ECHO_TIMEOUT;
            cm_div     = RST_US_PER_CM;
            phase      = RNG_IDLE;
            ticks      = '0;
            prescale   = '0;
            dist_acc   = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TRIGGER_US:   trig_len   = i_cfg_data[TRIG_W-1:0];
                    REG_RISE_TIMEOUT: rise_limit = i_cfg_data[CNT_W-1:0];
                    REG_ECHO_TIMEOUT: echo_limit = i_cfg_data[CNT_W-1:0];
                    REG_US_PER_CM:    cm_div     = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.trig     = i_trigger_out;
                got.busy     = i_busy_res;
                got.done     = i_done_res;
                got.status   = i_status;
                got.distance = i_distance_cm;
                if (expected_reports.size() == 0) begin
                    $error("result with no request waiting");
                    fails++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("trigger_out", want.trig, got.trig);
                    check_field("busy_res", want.busy, got.busy);
                    check_field("done_res", want.done, got.done);
                    check_field("status", want.status, got.status);
                    check_field("distance_cm", want.distance, got.distance);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_tick(i_start_req, i_echo_level, want);
                expected_reports.push_back(want);
            end
        end
        o_pending    = expected_reports.size();
        o_fail_count = fails;
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// stimulus, register settings and verdict for the ultrasonic echo ranger
// depends on uer_pkg, ultrasonic_echo_ranger and echo_ranger_monitor
module tb_top;
    import uer_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NO_LIMIT       = 32'h7fff_ffff;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cfg_we     = 1'b0;
    logic [IDX_W-1:0]  cfg_idx    = '0;
    logic [DATA_W-1:0] cfg_data   = '0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              start_req  = 1'b0;
    logic              echo_level = 1'b0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic              trigger_out;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        status;
    logic [CNT_W-1:0]  distance_cm;
    int                fail_count;
    int                pending;

    int send_pct     = 0;
    int recv_pct     = 0;
    int tick_budget  = NO_LIMIT;
    int items_sent   = 0;
    int quiet_cycles = 0;
    int cur_trig     = int'(RST_TRIGGER_US);
    int cur_rise     = int'(RST_RISE_TIMEOUT);
    int cur_echo     = int'(RST_ECHO_TIMEOUT);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ultrasonic_echo_ranger dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_start_req   (start_req),
        .i_echo_level  (echo_level),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_trigger_out (trigger_out),
        .o_busy_res    (busy_res),
        .o_done_res    (done_res),
        .o_status      (status),
        .o_distance_cm (distance_cm)
    );

    echo_ranger_monitor monitor (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_start_req   (start_req),
        .i_echo_level  (echo_level),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_trigger_out (trigger_out),
        .i_busy_res    (busy_res),
        .i_done_res    (done_res),
        .i_status      (status),
        .i_distance_cm (distance_cm),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idle(input t_idle mode);
        case (mode)
            IDLE_SEND: begin send_pct = 84; recv_pct = 0;  end
            IDLE_RECV: begin send_pct = 0;  recv_pct = 84; end
            IDLE_BOTH: begin send_pct = 9;  recv_pct = 9;  end
            default:   begin send_pct = 0;  recv_pct = 0;  end
        endcase
    endtask

    // one microsecond tick request; valid stays high after acceptance
    task automatic tick(input logic start, input logic echo);
        if (tick_budget > 0) begin
            tick_budget--;
            if ($urandom_range(0, 99) < send_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(0, 99) < send_pct) @(posedge clk);
            end
            in_valid   <= 1'b1;
            start_req  <= start;
            echo_level <= echo;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            items_sent++;
        end
    endtask

    function automatic logic rare_start();
        return ($urandom_range(0, 7) == 0);
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic apply_setting(input int trig, input int rise, input int echo, input int cm,
                                 input t_idle mode);
        drain();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_TRIGGER_US;
        cfg_data <= DATA_W'(trig);
        @(posedge clk);
        cfg_idx  <= REG_RISE_TIMEOUT;
        cfg_data <= DATA_W'(rise);
        @(posedge clk);
        cfg_idx  <= REG_ECHO_TIMEOUT;
        cfg_data <= DATA_W'(echo);
        @(posedge clk);
        cfg_idx  <= REG_US_PER_CM;
        cfg_data <= DATA_W'(cm);
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_trig = trig;
        cur_rise = rise;
        cur_echo = echo;
        set_idle(mode);
    endtask

    // start, full trigger pulse, wait for rise, then echo high and echo low, or no rise until the rise timeout
    task automatic run_ping(input int wcap, input int hcap);
        int trig_eff;
        int rise_eff;
        int echo_eff;
        int wait_len;
        int high_len;
        trig_eff = (cur_trig == 0) ? 1 : cur_trig;
        rise_eff = (cur_rise == 0) ? 1 : cur_rise;
        echo_eff = (cur_echo == 0) ? 1 : cur_echo;
        tick(1'b1, 1'($urandom_range(0, 1)));
        repeat (2 * trig_eff - 1) tick(rare_start(), 1'($urandom_range(0, 1)));
        wait_len = $urandom_range(0, (rise_eff < wcap) ? rise_eff : wcap);
        if (wait_len >= rise_eff) begin
            repeat (rise_eff) tick(rare_start(), 1'b0);
        end else begin
            repeat (wait_len) tick(rare_start(), 1'b0);
            high_len = $urandom_range(1, (echo_eff < hcap) ? echo_eff : hcap);
            repeat (high_len) tick(rare_start(), 1'b1);
            tick((high_len < echo_eff) ? rare_start() : 1'b0, 1'b0);
        end
        repeat ($urandom_range(0, 3)) tick(1'b0, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_traffic(input int count, input int wcap, input int hcap);
        int first_item;
        first_item = items_sent;
        while (items_sent - first_item < count) begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 8))
                    tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                1: begin
                    tick_budget = $urandom_range(1, 12);
                    run_ping(wcap, hcap);
                    tick_budget = NO_LIMIT;
                end
                default: run_ping(wcap, hcap);
            endcase
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        set_idle(IDLE_NONE);
        run_traffic(40, 10, 70);

        apply_setting(1, 2, 3, 1, IDLE_NONE);
        tick(1'b0, 1'b1);
        tick(1'b0, 1'b0);
        // echo never rises
        tick(1'b1, 1'b0);
        tick(1'b1, 1'b1);
        tick(1'b0, 1'b0);
        tick(1'b0, 1'b0);
        // echo stuck high, start ignored on the finishing tick
        tick(1'b1, 1'b1);
        tick(1'b0, 1'b0);
        tick(1'b0, 1'b1);
        tick(1'b1, 1'b1);
        tick(1'b1, 1'b1);
        tick(1'b0, 1'b0);
        // single high tick
        tick(1'b1, 1'b0);
        tick(1'b0, 1'b0);
        tick(1'b0, 1'b0);
        tick(1'b0, 1'b1);
        tick(1'b1, 1'b0);
        tick(1'b0, 1'b0);
        // rise on the first wait tick
        tick(1'b1, 1'b1);
        tick(1'b0, 1'b1);
        tick(1'b0, 1'b1);
        tick(1'b0, 1'b1);
        tick(1'b0, 1'b0);

        apply_setting(1, 4, 6, 2, IDLE_NONE);
        run_traffic(60, 6, 10);
        apply_setting(2, 8, 20, 3, IDLE_SEND);
        run_traffic(60, 10, 25);
        apply_setting(0, 0, 0, 0, IDLE_RECV);
        run_traffic(40, 3, 4);
        apply_setting(3, 65535, 65535, 65535, IDLE_BOTH);
        run_traffic(40, 12, 40);
        apply_setting(20, 5, 10, 1, IDLE_NONE);
        run_traffic(50, 6, 12);
        apply_setting(5, 12, 30, 7, IDLE_RECV);
        run_traffic(60, 14, 34);
        apply_setting(1, 1, 1, 65535, IDLE_SEND);
        run_traffic(40, 2, 3);
        apply_setting(4, 20, 200, 16, IDLE_BOTH);
        run_traffic(40, 22, 120);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
